// ===== src/bhpq_pkg.sv =====
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int unsigned DefDepth = 1024;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned TagW     = 16;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_RESERVED = 2'd3
  } bhpq_op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_EMPTY  = 2'd2,
    STATUS_BEYOND = 2'd3
  } bhpq_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RM_RD_LAST,
    S_RM_LOAD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_LR,
    S_DN_CMP,
    S_FINISH
  } bhpq_state_e;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [KeyW-1:0] key;
  } bhpq_entry_t;

  typedef struct packed {
    bhpq_status_e    status;
    logic [TagW-1:0] tag;
    logic [KeyW-1:0] key;
  } bhpq_res_t;

endpackage

// ===== src/binary_heap_priority_queue.sv =====
`timescale 1ns / 1ps

// Priority queue kept as a binary heap in a single on-chip RAM.
// Requests arrive on the s_axis channel: tuser carries the operation (insert,
// extract top, remove at position), tdata the key, tag and one-based position.
// Every request yields exactly one transaction on m_axis: tuser is the status,
// tdata the removed key and tag (zero when nothing is removed) and the fill.
// cfg_we_i/cfg_wdata_i write the order bit (0 smallest key on top, 1 largest);
// write it only while no request is in flight.
// One request is worked on at a time; s_axis_tready is high only between
// requests, so a new one is taken only after the last result leaves the controller.
// Work from acceptance to result in the output register:
//   insert: the new entry climbs from the last slot level by level;
//   extract/remove: the entry is read out and, unless it was the last one,
//   the last entry fills the hole and then climbs or sinks level by level;
//   rejected requests and the unused op go straight to the result.
// The single registered RAM read port and the one comparator set the pace
// of each step.
// The result sits in an output register, so the next request is taken while
// the receiver stalls; a further result then waits until that one is taken.
// Reset empties the queue and selects smallest-on-top; the RAM is not cleared.
module binary_heap_priority_queue #(
  parameter int unsigned DEPTH = bhpq_pkg::DefDepth,
  localparam int unsigned CntW  = $clog2(DEPTH + 1),
  localparam int unsigned DataW = ((bhpq_pkg::KeyW + bhpq_pkg::TagW + CntW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [DataW-1:0]             s_axis_tdata,  // key, tag, position, zero pad
  input  logic [bhpq_pkg::OpW-1:0]     s_axis_tuser,  // op
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [DataW-1:0]             m_axis_tdata,  // out_key, out_tag, fill, zero pad
  output logic [bhpq_pkg::StatusW-1:0] m_axis_tuser   // status
);

  import bhpq_pkg::*;

  logic order_max_q;

  logic            res_valid;
  logic            res_ready;
  bhpq_res_t       res;
  logic [CntW-1:0] res_fill;

  logic            out_valid_q;
  bhpq_res_t       out_res_q;
  logic [CntW-1:0] out_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_max_q <= 1'b0;
    end else if (cfg_we_i) begin
      order_max_q <= cfg_wdata_i;
    end
  end

  bhpq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .order_max_i (order_max_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (bhpq_op_e'(s_axis_tuser)),
    .in_key_i    (s_axis_tdata[KeyW-1:0]),
    .in_tag_i    (s_axis_tdata[KeyW+TagW-1:KeyW]),
    .in_pos_i    (s_axis_tdata[KeyW+TagW+CntW-1:KeyW+TagW]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .res_fill_o  (res_fill)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q  <= res;
      out_fill_q <= res_fill;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataW'({out_fill_q, out_res_q.tag, out_res_q.key});
  assign m_axis_tuser  = out_res_q.status;

endmodule

// ===== src/bhpq_ram.sv =====
`timescale 1ns / 1ps

module bhpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bhpq_cmp.sv =====
`timescale 1ns / 1ps

module bhpq_cmp (
  input  logic [bhpq_pkg::KeyW-1:0] a_i,
  input  logic [bhpq_pkg::KeyW-1:0] b_i,
  input  logic                      order_max_i,
  output logic                      beats_o
);

  import bhpq_pkg::*;

  logic a_lt_b;
  logic a_gt_b;

  assign a_lt_b  = (a_i < b_i);
  assign a_gt_b  = (a_i > b_i);
  // strict in both orders: equal keys never beat each other
  assign beats_o = order_max_i ? a_gt_b : a_lt_b;

endmodule

// ===== src/bhpq_ctrl.sv =====
`timescale 1ns / 1ps

module bhpq_ctrl #(
  parameter int unsigned DEPTH = bhpq_pkg::DefDepth,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      order_max_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bhpq_pkg::bhpq_op_e        in_op_i,
  input  logic [bhpq_pkg::KeyW-1:0] in_key_i,
  input  logic [bhpq_pkg::TagW-1:0] in_tag_i,
  input  logic [CntW-1:0]           in_pos_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output bhpq_pkg::bhpq_res_t       res_o,
  output logic [CntW-1:0]           res_fill_o
);

  import bhpq_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned EntW  = $bits(bhpq_entry_t);

  bhpq_state_e state_q, state_d;

  bhpq_op_e        op_q;
  logic [KeyW-1:0] key_q;
  logic [TagW-1:0] tag_q;
  logic [CntW-1:0] pos_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] p_q, p_d;
  logic [CntW-1:0] cpos_q, cpos_d;
  logic            climb_q, climb_d;
  bhpq_entry_t     ent_q, ent_d;
  bhpq_entry_t     cand_q, cand_d;
  bhpq_res_t       res_q, res_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  bhpq_entry_t      ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  bhpq_entry_t      ram_rdata;
  logic [EntW-1:0]  ram_rdata_raw;

  logic [KeyW-1:0] cmp_a;
  logic [KeyW-1:0] cmp_b;
  logic            cmp_beats;

  logic [CntW-1:0] p_m1;
  logic [CntW-1:0] par;
  logic [CntW-1:0] par_m1;
  logic [CntW-1:0] cnt_m1;
  logic [CntW:0]   lc;
  logic [CntW:0]   lc_m1;
  logic [CntW:0]   rc;
  logic [CntW:0]   cnt_ext;
  logic [CntW-1:0] rm_pos;
  logic [CntW-1:0] rm_pos_m1;

  assign p_m1      = p_q - CntW'(1);
  assign par       = p_q >> 1;
  assign par_m1    = par - CntW'(1);
  assign cnt_m1    = cnt_q - CntW'(1);
  assign lc        = {p_q, 1'b0};
  assign lc_m1     = lc - (CntW + 1)'(1);
  assign rc        = {p_q, 1'b1};
  assign cnt_ext   = {1'b0, cnt_q};
  assign rm_pos    = (op_q == OP_EXTRACT) ? CntW'(1) : pos_q;
  assign rm_pos_m1 = rm_pos - CntW'(1);

  bhpq_ram #(
    .Width (EntW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = bhpq_entry_t'(ram_rdata_raw);
  // every write lands at the current hole
  assign ram_waddr = p_m1[AddrW-1:0];

  bhpq_cmp u_cmp (
    .a_i         (cmp_a),
    .b_i         (cmp_b),
    .order_max_i (order_max_i),
    .beats_o     (cmp_beats)
  );

  always_comb begin
    cmp_a = ent_q.key;
    cmp_b = ram_rdata.key;
    case (state_q)
      S_DN_LR: begin
        cmp_a = cand_q.key;
        cmp_b = ram_rdata.key;
      end
      S_DN_CMP: begin
        cmp_a = ent_q.key;
        cmp_b = cand_q.key;
      end
      default: begin
        cmp_a = ent_q.key;
        cmp_b = ram_rdata.key;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      climb_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      climb_q <= climb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= in_op_i;
      key_q <= in_key_i;
      tag_q <= in_tag_i;
      pos_q <= in_pos_i;
    end
    p_q    <= p_d;
    cpos_q <= cpos_d;
    ent_q  <= ent_d;
    cand_q <= cand_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    cpos_d      = cpos_q;
    climb_d     = climb_q;
    ent_d       = ent_q;
    cand_d      = cand_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_wdata   = ent_q;
    ram_re      = 1'b0;
    ram_raddr   = p_m1[AddrW-1:0];
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_d.key    = '0;
        res_d.tag    = '0;
        res_d.status = STATUS_OK;
        state_d      = S_FINISH;
        case (op_q)
          OP_INSERT: begin
            if (cnt_q == CntW'(DEPTH)) begin
              res_d.status = STATUS_FULL;
            end else begin
              cnt_d     = cnt_q + CntW'(1);
              p_d       = cnt_q + CntW'(1);
              ent_d.key = key_q;
              ent_d.tag = tag_q;
              climb_d   = 1'b1;
              state_d   = S_UP_RD;
            end
          end
          OP_EXTRACT, OP_REMOVE: begin
            if (cnt_q == '0) begin
              res_d.status = STATUS_EMPTY;
            end else if (op_q == OP_REMOVE && (pos_q == '0 || pos_q > cnt_q)) begin
              res_d.status = STATUS_BEYOND;
            end else begin
              p_d       = rm_pos;
              ram_re    = 1'b1;
              ram_raddr = rm_pos_m1[AddrW-1:0];
              state_d   = S_RM_RD_LAST;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end

      S_RM_RD_LAST: begin
        // read data is the entry being taken out
        res_d.key = ram_rdata.key;
        res_d.tag = ram_rdata.tag;
        ram_re    = 1'b1;
        ram_raddr = cnt_m1[AddrW-1:0];
        state_d   = S_RM_LOAD;
      end

      S_RM_LOAD: begin
        // last entry becomes the one that fills the hole
        ent_d   = ram_rdata;
        cnt_d   = cnt_m1;
        climb_d = 1'b0;
        if (p_q == cnt_q) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_UP_RD;
        end
      end

      S_UP_RD: begin
        if (p_q == CntW'(1)) begin
          if (climb_q) begin
            ram_we  = 1'b1;
            state_d = S_FINISH;
          end else begin
            state_d = S_DN_RDL;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = par_m1[AddrW-1:0];
          state_d   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (cmp_beats) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          p_d       = par;
          climb_d   = 1'b1;
          state_d   = S_UP_RD;
        end else if (climb_q) begin
          ram_we  = 1'b1;
          state_d = S_FINISH;
        end else begin
          state_d = S_DN_RDL;
        end
      end

      S_DN_RDL: begin
        if (lc > cnt_ext) begin
          ram_we  = 1'b1;
          state_d = S_FINISH;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = lc_m1[AddrW-1:0];
          state_d   = S_DN_RDR;
        end
      end

      S_DN_RDR: begin
        cand_d = ram_rdata;
        cpos_d = lc[CntW-1:0];
        if (rc <= cnt_ext) begin
          // right child sits at address 2p
          ram_re    = 1'b1;
          ram_raddr = lc[AddrW-1:0];
          state_d   = S_DN_LR;
        end else begin
          state_d = S_DN_CMP;
        end
      end

      S_DN_LR: begin
        // left child wins only if strictly better
        if (!cmp_beats) begin
          cand_d = ram_rdata;
          cpos_d = rc[CntW-1:0];
        end
        state_d = S_DN_CMP;
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (cmp_beats) begin
          state_d = S_FINISH;
        end else begin
          ram_wdata = cand_q;
          p_d       = cpos_q;
          state_d   = S_DN_RDL;
        end
      end

      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o      = res_q;
  assign res_fill_o = cnt_q;

  logic in_sift;
  assign in_sift = (state_q == S_UP_RD) || (state_q == S_UP_CMP) ||
                   (state_q == S_DN_RDL) || (state_q == S_DN_RDR) ||
                   (state_q == S_DN_LR) || (state_q == S_DN_CMP);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_cnt_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ($past(state_q) == S_DISPATCH || $past(state_q) == S_RM_LOAD))
    else $error("entry count moved outside dispatch or removal load");

  a_hole_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_sift |-> (p_q != '0 && p_q <= cnt_q))
    else $error("hole position outside the heap during a sift");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_FINISH || state_q == S_DISPATCH) |-> !ram_we)
    else $error("heap written outside a sift");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bhpq_pkg::*;

  localparam int unsigned PosW       = $clog2(DefDepth + 1);
  localparam int unsigned DataW      = ((KeyW + TagW + PosW + 7) / 8) * 8;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    bhpq_status_e    status;
    logic [PosW-1:0] fill;
    logic [TagW-1:0] tag;
    logic [KeyW-1:0] key;
  } heap_result_t;

  // Shadow heap: predicts each reply and holds the replies still owed.
  class heap_scoreboard;
    logic [KeyW-1:0] keys [1:DefDepth];
    logic [TagW-1:0] tags [1:DefDepth];
    int unsigned     fill_count;
    bit              order_max;
    int unsigned     failures;
    heap_result_t    awaited[$];

    function bit wins(int unsigned a, int unsigned b);
      if (order_max) return keys[a] > keys[b];
      return keys[a] < keys[b];
    endfunction

    function void swap_entries(int unsigned a, int unsigned b);
      logic [KeyW-1:0] k;
      logic [TagW-1:0] t;
      k = keys[a]; keys[a] = keys[b]; keys[b] = k;
      t = tags[a]; tags[a] = tags[b]; tags[b] = t;
    endfunction

    function void climb(int unsigned p);
      while (p > 1 && wins(p, p / 2)) begin
        swap_entries(p, p / 2);
        p = p / 2;
      end
    endfunction

    // equal keys keep sinking: stop only when strictly better than the child
    function void sink(int unsigned p);
      int unsigned c;
      forever begin
        if (2 * p > fill_count) return;
        if (2 * p + 1 > fill_count || wins(2 * p, 2 * p + 1)) c = 2 * p;
        else c = 2 * p + 1;
        if (wins(p, c)) return;
        swap_entries(p, c);
        p = c;
      end
    endfunction

    function void note_request(bhpq_op_e op, logic [KeyW-1:0] key, logic [TagW-1:0] tag,
                               logic [PosW-1:0] pos);
      heap_result_t res;
      int unsigned  p;
      res = '0;
      res.status = STATUS_OK;
      case (op)
        OP_INSERT: begin
          if (fill_count >= DefDepth) begin
            res.status = STATUS_FULL;
          end else begin
            fill_count++;
            keys[fill_count] = key;
            tags[fill_count] = tag;
            climb(fill_count);
          end
        end
        OP_EXTRACT, OP_REMOVE: begin
          p = (op == OP_EXTRACT) ? 1 : pos;
          if (fill_count == 0) begin
            res.status = STATUS_EMPTY;
          end else if (p == 0 || p > fill_count) begin
            res.status = STATUS_BEYOND;
          end else begin
            res.key = keys[p];
            res.tag = tags[p];
            if (p != fill_count) begin
              // last entry fills the hole, then moves whichever way it must
              keys[p] = keys[fill_count];
              tags[p] = tags[fill_count];
              fill_count--;
              if (p > 1 && wins(p, p / 2)) climb(p);
              else sink(p);
            end else begin
              fill_count--;
            end
          end
        end
        default: ;
      endcase
      res.fill = fill_count;
      awaited.push_back(res);
    endfunction

    function void compare_field(string name, logic [KeyW-1:0] want, logic [KeyW-1:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= MaxReports)
          $display("%t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      end
    endfunction

    function void check_result(logic [DataW-1:0] data, logic [StatusW-1:0] status);
      heap_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("%t: reply with nothing outstanding, tdata %0h", $realtime, data);
        return;
      end
      want = awaited.pop_front();
      compare_field("out_key", want.key, data[KeyW-1:0]);
      compare_field("out_tag", KeyW'(want.tag), KeyW'(data[KeyW +: TagW]));
      compare_field("fill", KeyW'(want.fill), KeyW'(data[KeyW + TagW +: PosW]));
      compare_field("status", KeyW'(want.status), KeyW'(status));
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]    s_axis_tuser = OP_RESERVED;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DataW-1:0]  m_axis_tdata;
  logic [StatusW-1:0] m_axis_tuser;

  bit                steady = 1'b0;
  int unsigned       quiet_cycles = 0;
  heap_scoreboard    queue_model;

  binary_heap_priority_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) m_axis_tready = steady || ($urandom_range(0, 99) >= 16);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      queue_model.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("binary_heap_priority_queue verification failed");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_request(input bhpq_op_e op, input logic [KeyW-1:0] key,
                              input logic [TagW-1:0] tag, input logic [PosW-1:0] pos);
    while (!steady && $urandom_range(0, 99) < 16) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = DataW'({pos, tag, key});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    queue_model.note_request(op, key, tag, pos);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (queue_model.pending() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_order(input bit order);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = order;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    queue_model.order_max = order;
  endtask

  // bias towards the values 0 to 7 and their complements so that equal keys are common
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return KeyW'($urandom_range(0, 7));
    if (r < 36) return '0;
    if (r < 42) return '1;
    if (r < 50) return ~KeyW'($urandom_range(0, 7));
    return KeyW'($urandom);
  endfunction

  function automatic logic [TagW-1:0] pick_tag();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return TagW'($urandom_range(0, (1 << TagW) - 1));
  endfunction

  task automatic random_request(input int unsigned ins_pct, input int unsigned ext_pct,
                                input int unsigned rem_pct);
    int unsigned     r;
    int unsigned     top;
    bhpq_op_e        op;
    logic [PosW-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < ins_pct) op = OP_INSERT;
    else if (r < ins_pct + ext_pct) op = OP_EXTRACT;
    else if (r < ins_pct + ext_pct + rem_pct) op = OP_REMOVE;
    else op = OP_RESERVED;
    top = (queue_model.fill_count > 0) ? queue_model.fill_count : 1;
    r = $urandom_range(0, 99);
    if (r < 80) pos = PosW'($urandom_range(1, top));
    else if (r < 88) pos = PosW'(top);
    else if (r < 93) pos = '0;
    else pos = PosW'($urandom_range(0, (1 << PosW) - 1));
    send_request(op, pick_key(), pick_tag(), pos);
  endtask

  initial begin
    int unsigned n;
    queue_model = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_order(1'b0);
    // empty queue, reserved op, key and tag extremes, ties, out-of-range positions
    send_request(OP_EXTRACT, '1, '1, PosW'(1));
    send_request(OP_REMOVE, '0, '0, PosW'(1));
    send_request(OP_RESERVED, '1, '1, '1);
    send_request(OP_INSERT, '1, '1, '0);
    send_request(OP_INSERT, '0, '0, '1);
    send_request(OP_INSERT, KeyW'(5), TagW'(16'h1234), '0);
    send_request(OP_INSERT, KeyW'(5), TagW'(16'h4321), '0);
    send_request(OP_INSERT, KeyW'(5), TagW'(16'haaaa), '0);
    send_request(OP_INSERT, KeyW'(32'h8000_0000), TagW'(16'h5555), '0);
    send_request(OP_RESERVED, KeyW'(32'h1234_5678), TagW'(16'h9abc), PosW'(3));
    send_request(OP_REMOVE, '0, '0, '0);
    send_request(OP_REMOVE, '0, '0, PosW'(7));
    send_request(OP_REMOVE, '0, '0, '1);
    send_request(OP_REMOVE, '0, '0, PosW'(6));  // last slot: plain drop
    send_request(OP_REMOVE, '0, '0, PosW'(2));
    send_request(OP_INSERT, KeyW'(1), TagW'(1), '0);
    send_request(OP_INSERT, KeyW'(2), TagW'(2), '0);
    send_request(OP_INSERT, KeyW'(3), TagW'(3), '0);
    send_request(OP_REMOVE, '0, '0, PosW'(3));
    send_request(OP_EXTRACT, '0, '0, '0);
    send_request(OP_EXTRACT, '0, '0, '0);
    send_request(OP_REMOVE, '0, '0, PosW'(1));

    write_order(1'b1);
    for (int i = 0; i < 250; i++) begin
      if (i == 125) wait_drained();
      random_request(50, 20, 25);
    end

    // fill to capacity, with a long run free of idle cycles
    write_order(1'b0);
    n = 0;
    while (queue_model.fill_count < DefDepth) begin
      steady = (n >= 200 && n < 500);
      random_request(94, 2, 3);
      n++;
    end
    steady = 1'b0;
    repeat (6) send_request(OP_INSERT, pick_key(), pick_tag(), '0);

    // flip the order with a full heap and drain part of it
    write_order(1'b1);
    for (int i = 0; i < 120; i++) random_request(20, 35, 40);

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (queue_model.failures == 0 && queue_model.pending() == 0) begin
      $display("binary_heap_priority_queue verification clean");
    end else begin
      $display("binary_heap_priority_queue verification failed");
    end
    $finish;
  end

endmodule
